// File: design/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and codes of the double-hashing Bloom filter unit.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    // Fixed field widths
    localparam int HASH_W       = 64;
    localparam int MODE_W       = 2;
    localparam int NUM_BITS_W   = 17;
    localparam int NUM_HASHES_W = 5;
    localparam int COUNT_W      = 17;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int STEP_W       = 6;
    localparam int ROW_W        = 64;
    localparam int OFF_W        = 6;

    // Transaction modes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 1'd1;

    // Configuration reset values
    localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 17'd65536;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 5'd4;

    // Last step of the bit-serial modulo
    localparam logic [STEP_W-1:0] STEP_LAST = 6'd63;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic mem_read;
        logic mem_check;
        logic next_hash;
        logic clr_start;
        logic clr_write;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              k_zero;
        logic              div_last;
        logic              hash_last;
        logic              clr_last;
        logic              out_free;
    } t_stat;

endpackage

// File: design/bfdh_req_if.sv
// ----------------------------------------------------------------------------
// bfdh_req_if
// Request channel: mode and the two precomputed key hashes.
// ----------------------------------------------------------------------------
interface bfdh_req_if;
    import bfdh_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [HASH_W-1:0] first_hash;
    logic [HASH_W-1:0] second_hash;

    modport source (output valid, output mode, output first_hash, output second_hash,
                    input ready);
    modport sink   (input valid, input mode, input first_hash, input second_hash,
                    output ready);
endinterface

// File: design/bfdh_rsp_if.sv
// ----------------------------------------------------------------------------
// bfdh_rsp_if
// Response channel: membership answer and set-bit count.
// ----------------------------------------------------------------------------
interface bfdh_rsp_if;
    import bfdh_pkg::*;

    logic               valid;
    logic               ready;
    logic               might_contain;
    logic [COUNT_W-1:0] set_bit_count;

    modport source (output valid, output might_contain, output set_bit_count,
                    input ready);
    modport sink   (input valid, input might_contain, input set_bit_count,
                    output ready);
endinterface

// File: design/bfdh_ctrl.sv
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer of the filter: clearing pass, per-hash modulo, read-modify-write.
// ----------------------------------------------------------------------------
module bfdh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  bfdh_pkg::t_stat  i_stat,
    output bfdh_pkg::t_cmd   o_cmd
);
    import bfdh_pkg::*;

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_DIV      = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_CHECK    = 3'd5;
    localparam logic [2:0] S_CLEAR    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Decode state into commands and next state
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.mode)
                    MODE_ADD, MODE_QUERY: begin
                        n_state = i_stat.k_zero ? S_DONE : S_DIV;
                    end
                    MODE_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.mem_check = 1'b1;
                o_cmd.next_hash = 1'b1;
                n_state         = i_stat.hash_last ? S_DONE : S_DIV;
            end
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/bfdh_dp.sv
// ----------------------------------------------------------------------------
// bfdh_dp
// Datapath: configuration, index generation, bit-serial modulo, bit store,
// set-bit counter and output register.
// ----------------------------------------------------------------------------
module bfdh_dp #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [bfdh_pkg::MODE_W-1:0]         i_mode,
    input  logic [bfdh_pkg::HASH_W-1:0]         i_first_hash,
    input  logic [bfdh_pkg::HASH_W-1:0]         i_second_hash,
    input  bfdh_pkg::t_cmd                      i_cmd,
    output bfdh_pkg::t_stat                     o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_might_contain,
    output logic [bfdh_pkg::COUNT_W-1:0]        o_set_bit_count
);
    import bfdh_pkg::*;

    localparam int WORDS = (MAX_BITS + 63) / 64;
    localparam int RAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MW    = $clog2(MAX_BITS + 1);
    localparam int KW    = $clog2(MAX_HASHES + 1);

    // Configuration registers
    logic [NUM_BITS_W-1:0]   r_num_bits;
    logic [NUM_HASHES_W-1:0] r_num_hashes;

    // Item state
    logic [MODE_W-1:0] r_mode;
    logic [HASH_W-1:0] r_sum;
    logic [HASH_W-1:0] r_h2;
    logic [MW-1:0]     r_m;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_hidx;
    logic              r_hit;

    // Modulo unit
    logic [HASH_W-1:0] r_div;
    logic [MW-1:0]     r_rem;
    logic [STEP_W-1:0] r_step;

    // Store and counter
    logic [ROW_W-1:0]  mem [WORDS];
    logic [ROW_W-1:0]  r_rdata;
    logic [RAW-1:0]    r_caddr;
    logic [MW-1:0]     r_count;

    // Output register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [COUNT_W-1:0] r_out_cnt;

    logic [MW-1:0]     m_eff;
    logic [KW-1:0]     k_eff;
    logic [MW:0]       div_trial;
    logic [MW:0]       div_red;
    logic [HASH_W-1:0] sum_next;
    logic [RAW-1:0]    row;
    logic [OFF_W-1:0]  off;
    logic [ROW_W-1:0]  mask;
    logic              bit_set;
    logic              set_new;
    logic              mem_we;
    logic [RAW-1:0]    mem_addr;
    logic [ROW_W-1:0]  mem_wdata;

    // Clamp modulus and hash count
    always_comb begin
        if (r_num_bits == '0) begin
            m_eff = MW'(1);
        end else if (32'(r_num_bits) > 32'(MAX_BITS)) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(r_num_bits);
        end
        if (32'(r_num_hashes) > 32'(MAX_HASHES)) begin
            k_eff = KW'(MAX_HASHES);
        end else begin
            k_eff = KW'(r_num_hashes);
        end
    end

    // One restoring step of the modulo
    always_comb begin
        div_trial = {r_rem, r_div[HASH_W-1]};
        div_red   = (div_trial >= {1'b0, r_m}) ? (div_trial - {1'b0, r_m}) : div_trial;
    end

    // Bit address, test and store port selection
    always_comb begin
        sum_next  = r_sum + r_h2;
        row       = RAW'(r_rem >> OFF_W);
        off       = r_rem[OFF_W-1:0];
        mask      = ROW_W'(1) << off;
        bit_set   = (r_rdata & mask) != '0;
        set_new   = i_cmd.mem_check && (r_mode == MODE_ADD) && !bit_set;
        mem_we    = i_cmd.clr_write || set_new;
        mem_addr  = i_cmd.clr_write ? r_caddr : row;
        mem_wdata = i_cmd.clr_write ? '0 : (r_rdata | mask);
    end

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= NUM_BITS_RST;
            r_num_hashes <= NUM_HASHES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_BITS:   r_num_bits   <= i_cfg_data[NUM_BITS_W-1:0];
                CFG_NUM_HASHES: r_num_hashes <= i_cfg_data[NUM_HASHES_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the transaction, step the modulo, advance to the next index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_sum  <= i_first_hash;
            r_h2   <= i_second_hash;
            r_m    <= m_eff;
            r_k    <= k_eff;
            r_hidx <= '0;
            r_hit  <= 1'b1;
            r_div  <= i_first_hash;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_red[MW-1:0];
            r_div  <= {r_div[HASH_W-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end else if (i_cmd.next_hash) begin
            r_sum  <= sum_next;
            r_div  <= sum_next;
            r_rem  <= '0;
            r_step <= '0;
            r_hidx <= r_hidx + KW'(1);
        end
        // Drop the hit flag on any clear bit of a query
        if (i_cmd.mem_check && (r_mode == MODE_QUERY) && !bit_set) begin
            r_hit <= 1'b0;
        end
    end

    // Bit store: one row port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        if (i_cmd.mem_read) r_rdata <= mem[mem_addr];
    end

    // Clear address and set-bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_caddr <= '0;
                r_count <= '0;
            end else if (i_cmd.clr_write) begin
                r_caddr <= r_caddr + RAW'(1);
            end
            if (set_new) r_count <= r_count + MW'(1);
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit <= (r_mode == MODE_QUERY) && r_hit;
            r_out_cnt <= COUNT_W'(r_count);
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.k_zero    = (r_k == '0);
        o_stat.div_last  = (r_step == STEP_LAST);
        o_stat.hash_last = ((r_hidx + KW'(1)) == r_k);
        o_stat.clr_last  = (r_caddr == RAW'(WORDS - 1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_might_contain = r_out_hit;
    assign o_set_bit_count = r_out_cnt;

endmodule

// File: design/bloom_filter_double_hash_unit.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// Bloom filter with double hashing over a one-bit store of MAX_BITS cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one transaction: mode (add, query, clear, count) and the
//   two 64-bit key hashes. o_rsp returns one transaction per request: the
//   query answer and the set-bit count after the request.
//   i_cfg_we / i_cfg_idx / i_cfg_data write num_bits (0) and num_hashes (1);
//   write them only while no request is in flight.
// Timing:
//   One request at a time. For add and query, each of the k indexes
//   (k = clamped num_hashes) runs a bit-serial modulo over its 64-bit
//   hash, then one store read and one check/write step. Count, and add
//   or query with k = 0, skip the per-index work. Clear sweeps the store
//   one 64-bit row per cycle. i_req.ready rises in the same cycle as the
//   response turns valid.
// Reset:
//   Synchronous, active low. After reset the store's (MAX_BITS+63)/64 rows
//   (1024 by default) are swept clear before i_req.ready rises.
// Stall:
//   The response sits in an output register until taken; the next request
//   may be accepted meanwhile, and its response waits for the slot.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bfdh_req_if.sink                         i_req,
    bfdh_rsp_if.source                       o_rsp
);
    import bfdh_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    // Sequence each transaction
    bfdh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Compute indices, hold the store and the response
    bfdh_dp #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_req.mode),
        .i_first_hash    (i_req.first_hash),
        .i_second_hash   (i_req.second_hash),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_might_contain (o_rsp.might_contain),
        .o_set_bit_count (o_rsp.set_bit_count)
    );

    assign i_req.ready = req_ready;

endmodule
